>>> sv/hsl_to_rgb_pixel_core_assert.svh
// Assertion macros shared by the checker files of the HSL to RGB pixel core.
`ifndef HSL_TO_RGB_PIXEL_CORE_ASSERT_SVH
`define HSL_TO_RGB_PIXEL_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define HSL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define HSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition that holds on every clock edge, reset included.
`define HSL_ASSERT_ALWAYS(lbl, clk, cond, msg) \
	lbl: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

>>> sv/hsl2rgb_pkg.sv
// Shared types, constants and helpers of the HSL to RGB pixel core.
`default_nettype none

package hsl2rgb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FX_W      = FRAC_BITS + 1;
	localparam int H6_W      = FX_W + 2;
	localparam int SECT_W    = 3;
	localparam int CHAN_W    = 8;

	localparam logic [FX_W-1:0] ONE_FX  = FX_W'(1) << FRAC_BITS;
	localparam logic [FX_W-1:0] HALF_FX = FX_W'(1) << (FRAC_BITS - 1);

	typedef logic [FX_W-1:0] fx_t;

	// Hue sectors; the wrap code is a hue of exactly one full turn.
	typedef enum logic [SECT_W-1:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5,
		SEC_WRAP   = 3'd6
	} sector_t;

	typedef struct packed {
		fx_t                  lt;
		fx_t                  v;
		fx_t                  m;
		logic [SECT_W-1:0]    sector;
		logic [FRAC_BITS-1:0] frac;
	} chroma_t;

	typedef struct packed {
		fx_t r;
		fx_t g;
		fx_t b;
	} rgb_fx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} rgb8_t;

	function automatic fx_t sat_one(input fx_t x);
		return (x > ONE_FX) ? ONE_FX : x;
	endfunction

endpackage

`default_nettype wire

>>> sv/hsl2rgb_chroma.sv
// Two pipeline stages: input clamp and products, then chroma max and min.
`default_nettype none

module hsl2rgb_chroma (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire hsl2rgb_pkg::fx_t       hue,
	input  wire hsl2rgb_pkg::fx_t       saturation,
	input  wire hsl2rgb_pkg::fx_t       lightness,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output hsl2rgb_pkg::chroma_t        out_data
);

	localparam int FB = hsl2rgb_pkg::FRAC_BITS;
	localparam int FW = hsl2rgb_pkg::FX_W;
	localparam int HW = hsl2rgb_pkg::H6_W;

	logic valid_s1, valid_s2, ready_s1, ready_s2;

	hsl2rgb_pkg::fx_t h_c, s_c, l_c;
	logic [2*FW-1:0]  ls_full;
	logic [HW-1:0]    h6_c;

	logic [HW-1:0]    h6_s1;
	hsl2rgb_pkg::fx_t s_s1, l_s1, prod_s1;

	logic [FW+1:0]    vsum;
	hsl2rgb_pkg::fx_t v_c, m_c;
	logic [FW:0]      twice, m_raw;

	hsl2rgb_pkg::chroma_t chroma_s2;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Stage 1: clamp to one, lightness times saturation, hue times six.
	always_comb begin
		h_c     = hsl2rgb_pkg::sat_one(hue);
		s_c     = hsl2rgb_pkg::sat_one(saturation);
		l_c     = hsl2rgb_pkg::sat_one(lightness);
		ls_full = (2*FW)'(l_c) * (2*FW)'(s_c);
		h6_c    = (HW'(h_c) << 2) + (HW'(h_c) << 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			h6_s1   <= h6_c;
			s_s1    <= s_c;
			l_s1    <= l_c;
			prod_s1 <= ls_full[FB+FW-1:FB];
		end
	end

	// Stage 2: chroma maximum v and minimum m = 2L - v, clamped to [0, v].
	always_comb begin
		if (l_s1 <= hsl2rgb_pkg::HALF_FX) begin
			vsum = (FW+2)'(l_s1) + (FW+2)'(prod_s1);
		end else begin
			vsum = (FW+2)'(l_s1) + (FW+2)'(s_s1) - (FW+2)'(prod_s1);
		end
		v_c   = (vsum > (FW+2)'(hsl2rgb_pkg::ONE_FX)) ? hsl2rgb_pkg::ONE_FX : vsum[FW-1:0];
		twice = {l_s1, 1'b0};
		m_raw = (twice > (FW+1)'(v_c)) ? (twice - (FW+1)'(v_c)) : '0;
		m_c   = (m_raw > (FW+1)'(v_c)) ? v_c : m_raw[FW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			chroma_s2.lt     <= l_s1;
			chroma_s2.v      <= v_c;
			chroma_s2.m      <= m_c;
			chroma_s2.sector <= h6_s1[HW-1:FB];
			chroma_s2.frac   <= h6_s1[FB-1:0];
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = chroma_s2;

endmodule

`default_nettype wire

>>> sv/hsl2rgb_sector.sv
// Two pipeline stages: hue interpolation product, then sector channel select.
`default_nettype none

module hsl2rgb_sector (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire hsl2rgb_pkg::chroma_t   in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output hsl2rgb_pkg::rgb_fx_t        out_data
);

	localparam int FB = hsl2rgb_pkg::FRAC_BITS;
	localparam int FW = hsl2rgb_pkg::FX_W;
	localparam int PW = FW + FB;

	logic valid_s3, valid_s4, ready_s3, ready_s4;

	hsl2rgb_pkg::fx_t     diff;
	logic [PW-1:0]        span_prod;
	hsl2rgb_pkg::fx_t     vs0_s3;
	hsl2rgb_pkg::chroma_t chroma_s3;

	hsl2rgb_pkg::fx_t     c1, c2;
	hsl2rgb_pkg::rgb_fx_t pix_c, pix_s4;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	// Stage 3: vs0 = ((v - m) * frac) >> FRAC_BITS.
	always_comb begin
		diff      = in_data.v - in_data.m;
		span_prod = PW'(diff) * PW'(in_data.frac);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s3) begin
			vs0_s3    <= span_prod[PW-1:FB];
			chroma_s3 <= in_data;
		end
	end

	// Stage 4: rising and falling ramps, routed to channels by sector.
	always_comb begin
		c1    = chroma_s3.m + vs0_s3;
		c2    = chroma_s3.v - vs0_s3;
		pix_c = '{r: chroma_s3.lt, g: chroma_s3.lt, b: chroma_s3.lt};
		if (chroma_s3.v != '0) begin
			unique case (hsl2rgb_pkg::sector_t'(chroma_s3.sector))
				hsl2rgb_pkg::SEC_R_TO_Y: pix_c = '{r: chroma_s3.v, g: c1, b: chroma_s3.m};
				hsl2rgb_pkg::SEC_Y_TO_G: pix_c = '{r: c2, g: chroma_s3.v, b: chroma_s3.m};
				hsl2rgb_pkg::SEC_G_TO_C: pix_c = '{r: chroma_s3.m, g: chroma_s3.v, b: c1};
				hsl2rgb_pkg::SEC_C_TO_B: pix_c = '{r: chroma_s3.m, g: c2, b: chroma_s3.v};
				hsl2rgb_pkg::SEC_B_TO_M: pix_c = '{r: c1, g: chroma_s3.m, b: chroma_s3.v};
				hsl2rgb_pkg::SEC_M_TO_R: pix_c = '{r: chroma_s3.v, g: chroma_s3.m, b: c2};
				default: pix_c = '{r: chroma_s3.lt, g: chroma_s3.lt, b: chroma_s3.lt};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s4) begin
			pix_s4 <= pix_c;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = pix_s4;

endmodule

`default_nettype wire

>>> sv/hsl2rgb_quant.sv
// Output stage: scales each channel fraction to a byte and holds the result.
`default_nettype none

module hsl2rgb_quant (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire hsl2rgb_pkg::rgb_fx_t   in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output hsl2rgb_pkg::rgb8_t          out_data
);

	localparam int FB = hsl2rgb_pkg::FRAC_BITS;
	localparam int FW = hsl2rgb_pkg::FX_W;
	localparam int CW = hsl2rgb_pkg::CHAN_W;
	localparam int SW = FW + CW;

	logic valid_s5, ready_s5;
	logic [SW-1:0] r_sc, g_sc, b_sc;
	hsl2rgb_pkg::rgb8_t byte_s5;

	assign ready_s5 = !valid_s5 || out_ready;
	assign in_ready = ready_s5;

	// x * 255 as a shift and subtract; channels never exceed one here.
	always_comb begin
		r_sc = (SW'(in_data.r) << CW) - SW'(in_data.r);
		g_sc = (SW'(in_data.g) << CW) - SW'(in_data.g);
		b_sc = (SW'(in_data.b) << CW) - SW'(in_data.b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (ready_s5) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s5) begin
			byte_s5.r <= r_sc[FB+CW-1:FB];
			byte_s5.g <= g_sc[FB+CW-1:FB];
			byte_s5.b <= b_sc[FB+CW-1:FB];
		end
	end

	assign out_valid = valid_s5;
	assign out_data  = byte_s5;

endmodule

`default_nettype wire

>>> sv/hsl_to_rgb_pixel_core.sv
// An accepted beat passes stages s1 to s5 in order; every stage carries its own valid bit.
// Throughput: one pixel per clock unless the output stalls; every stage fills bubbles.
// The rate is set by the five-stage pipeline, each stage holding at most one multiplier.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// While a result waits, input beats keep flowing until all five stages hold a beat.
`default_nettype none

module hsl_to_rgb_pixel_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // hue[16:0], saturation[33:17], lightness[50:34], zero
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata   // red[7:0], green[15:8], blue[23:16]
);

	localparam int FW = hsl2rgb_pkg::FX_W;
	localparam int CW = hsl2rgb_pkg::CHAN_W;

	// Stage boundaries between the three units.
	logic                 chroma_valid, chroma_ready;
	hsl2rgb_pkg::chroma_t chroma_data;
	logic                 pix_valid, pix_ready;
	hsl2rgb_pkg::rgb_fx_t pix_data;
	hsl2rgb_pkg::rgb8_t   out_pix;

	// Stages one and two: clamp inputs, form the chroma maximum and minimum,
	// and split hue times six into a sector and a fraction.
	hsl2rgb_chroma u_chroma (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.hue        (s_axis_tdata[FW-1:0]),
		.saturation (s_axis_tdata[2*FW-1:FW]),
		.lightness  (s_axis_tdata[3*FW-1:2*FW]),
		.out_valid  (chroma_valid),
		.out_ready  (chroma_ready),
		.out_data   (chroma_data)
	);

	// Stages three and four: interpolate within the sector and route the
	// maximum, minimum and ramp values to red, green and blue. A zero
	// maximum or a hue of a full turn gives gray at the lightness.
	hsl2rgb_sector u_sector (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chroma_valid),
		.in_ready  (chroma_ready),
		.in_data   (chroma_data),
		.out_valid (pix_valid),
		.out_ready (pix_ready),
		.out_data  (pix_data)
	);

	// Stage five: scale each channel to 0..255 with truncation; this is
	// also the output register seen on the master side.
	hsl2rgb_quant u_quant (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_valid),
		.in_ready  (pix_ready),
		.in_data   (pix_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_pix)
	);

	assign m_axis_tdata = {out_pix.b, out_pix.g, out_pix.r};

	// Compile-time sanity: the byte layout above assumes three channels.
	localparam int OUT_W = 3 * CW;
	if (OUT_W != 24) begin : g_bad_width
		$error("output beat width mismatch");
	end

endmodule

`default_nettype wire

>>> sv/hsl2rgb_checker.sv
// Port-level checker of the HSL to RGB pixel core, bound to the top level.
`default_nettype none

`include "hsl_to_rgb_pixel_core_assert.svh"

module hsl2rgb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata
);

	logic out_stall;

	assign out_stall = m_axis_tvalid && !m_axis_tready;

	// With no result waiting, every stage has room, so the input side is open.
	`HSL_ASSERT_IMPL(a_ready_when_drained, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled")

	// A stalled output beat holds its value.
	`HSL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "beat lost")

	// Reset empties the pipeline at once.
	`HSL_ASSERT_ALWAYS(a_reset_empty, clk, arst_n || !m_axis_tvalid, "output valid during reset")

endmodule

bind hsl_to_rgb_pixel_core hsl2rgb_checker u_hsl2rgb_checker (.*);

`default_nettype wire

>>> bench/hsl_to_rgb_pixel_checker.sv
// Checker that predicts and compares every RGB result beat of the HSL to RGB pixel core.
`default_nettype none

module hsl_to_rgb_pixel_checker
	import hsl2rgb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // hue[16:0], saturation[33:17], lightness[50:34], zero
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [23:0] m_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
	output int               mismatches,
	output int               outstanding
);

	localparam int          SECTOR_COUNT = 6;
	localparam logic [7:0]  CHAN_FULL    = 8'hff;

	// Expected results in output beat layout, oldest first.
	logic [23:0] pending_rgb[$];

	function automatic fx_t clamp_unit(input fx_t x);
		return (x > ONE_FX) ? ONE_FX : x;
	endfunction

	function automatic logic [CHAN_W-1:0] scale_channel(input fx_t x);
		logic [FX_W+CHAN_W-1:0] scaled;
		scaled = x * CHAN_FULL;
		return scaled[FRAC_BITS +: CHAN_W];
	endfunction

	// Bit-exact prediction of one pixel, returned as red in the low byte.
	function automatic logic [23:0] hsl_to_rgb8(input fx_t hue_in, input fx_t sat_in,
			input fx_t light_in);
		fx_t                      h, s, lt, v, m, vs0, c1, c2, r, g, b;
		logic [2*FX_W-1:0]        ls_prod;
		logic [FX_W:0]            v_wide, twice, m_wide;
		logic [H6_W-1:0]          h6;
		logic [FRAC_BITS-1:0]     frac;
		logic [FX_W+FRAC_BITS-1:0] span_prod;
		sector_t                  sector;
		h  = clamp_unit(hue_in);
		s  = clamp_unit(sat_in);
		lt = clamp_unit(light_in);
		r  = lt;
		g  = lt;
		b  = lt;
		ls_prod = lt * s;
		if (lt <= HALF_FX) begin
			v_wide = lt + ls_prod[FRAC_BITS +: FX_W];
		end else begin
			v_wide = lt + s - ls_prod[FRAC_BITS +: FX_W];
		end
		v = (v_wide > ONE_FX) ? ONE_FX : v_wide[FX_W-1:0];
		if (v != '0) begin
			twice  = {lt, 1'b0};
			m_wide = (twice > v) ? twice - v : '0;
			m      = (m_wide > v) ? v : m_wide[FX_W-1:0];
			h6     = H6_W'(h * SECTOR_COUNT);
			sector = sector_t'(h6[H6_W-1:FRAC_BITS]);
			frac   = h6[FRAC_BITS-1:0];
			span_prod = (v - m) * frac;
			vs0 = span_prod[FRAC_BITS +: FX_W];
			c1  = m + vs0;
			c2  = v - vs0;
			case (sector)
				SEC_R_TO_Y: begin r = v;  g = c1; b = m;  end
				SEC_Y_TO_G: begin r = c2; g = v;  b = m;  end
				SEC_G_TO_C: begin r = m;  g = v;  b = c1; end
				SEC_C_TO_B: begin r = m;  g = c2; b = v;  end
				SEC_B_TO_M: begin r = c1; g = m;  b = v;  end
				SEC_M_TO_R: begin r = v;  g = m;  b = c2; end
				default: begin end
			endcase
		end
		return {scale_channel(b), scale_channel(g), scale_channel(r)};
	endfunction

	string chan_name[3] = '{"red", "green", "blue"};

	// Both channels are sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		logic [23:0] want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				pending_rgb = {pending_rgb, hsl_to_rgb8(s_axis_tdata[16:0],
					s_axis_tdata[33:17], s_axis_tdata[50:34])};
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_rgb.size() == 0) begin
					$display("%0t: unexpected result beat, actual %h", $time, m_axis_tdata);
					mismatches++;
				end else begin
					want = pending_rgb.pop_front();
					for (int ch = 0; ch < 3; ch++) begin
						if (m_axis_tdata[ch*8 +: 8] !== want[ch*8 +: 8]) begin
							$display("%0t: %s mismatch, expected %0d, actual %0d", $time,
								chan_name[ch], want[ch*8 +: 8], m_axis_tdata[ch*8 +: 8]);
							mismatches++;
						end
					end
				end
			end
			outstanding = pending_rgb.size();
		end
	end

endmodule

`default_nettype wire

>>> bench/tb_hsl_to_rgb_pixel_core.sv
// Testbench top for the HSL to RGB pixel core: stimulus, stalls and the final verdict.
`default_nettype none

module tb_hsl_to_rgb_pixel_core;
	import hsl2rgb_pkg::*;

	// Number of random pixels after the directed ones, and where the calm tail begins.
	localparam int RANDOM_COUNT = 1530;
	localparam int CALM_FROM    = RANDOM_COUNT - 250;
	// The receiver holds off once for this long after this many pixels went in.
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 200;
	// Settling time after the last result; the pipeline is five stages deep.
	localparam int DRAIN_CYCLES = 20;
	// Watchdog limit on the whole run, with a wide margin over the worst case.
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;   // hue[16:0], saturation[33:17], lightness[50:34], zero
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // red[7:0], green[15:8], blue[23:16]

	int mismatches;
	int outstanding;
	int pixels_sent = 0;
	// Set for the last part of the run, where neither side idles.
	bit calm = 1'b0;

	always #5 clk = ~clk;

	hsl_to_rgb_pixel_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	hsl_to_rgb_pixel_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// Offers one pixel beat from a falling edge and returns at the falling edge after
	// the beat was taken. A random gap may come first, outside the calm tail.
	task automatic send_pixel(input fx_t hue, input fx_t sat, input fx_t light);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_axis_tdata  <= {5'b0, light, sat, hue};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pixels_sent++;
		@(negedge clk);
	endtask

	// Mostly legal fractions, with the edges and out-of-range codes mixed in so that
	// every bit of the 17-bit fields is exercised.
	function automatic fx_t draw_fraction();
		case ($urandom_range(0, 15))
			0:       return fx_t'($urandom_range(0, 17'h1ffff));
			1:       return '0;
			2:       return ONE_FX;
			3:       return HALF_FX + fx_t'($urandom_range(0, 2)) - fx_t'(1);
			default: return fx_t'($urandom_range(0, ONE_FX));
		endcase
	endfunction

	// Receiver: short random stalls, one long hold-off that backs up the pipeline
	// and stalls the input, and steady acceptance in the calm tail.
	initial begin
		bit held = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && pixels_sent >= HOLD_AT) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(negedge clk);
		end
	end

	// Watchdog: a run that hangs is a failure.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		arst_n        = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. Black and zero lightness give a zero chroma maximum, which
		// falls back to gray.
		send_pixel('0, '0, '0);
		send_pixel(17'd20000, ONE_FX, '0);
		// A hue of exactly one full turn wraps to gray; above one saturates to it.
		send_pixel(ONE_FX, ONE_FX, HALF_FX);
		send_pixel(17'h10001, ONE_FX, HALF_FX);
		// Every field at its largest code, then hue and saturation above one.
		send_pixel(17'h1ffff, 17'h1ffff, 17'h1ffff);
		send_pixel(17'h18000, 17'h12345, 17'h0ffff);
		// Lightness just at and just above half switches the chroma formula.
		send_pixel(17'd3000, 17'd40000, HALF_FX);
		send_pixel(17'd3000, 17'd40000, HALF_FX + 17'd1);
		// White, full saturation and zero saturation.
		send_pixel(17'd30000, ONE_FX, ONE_FX);
		send_pixel(17'd30000, '0, 17'd12345);
		// One fully saturated color inside each of the six hue sectors.
		for (int k = 0; k < 6; k++) begin
			send_pixel(fx_t'(k * 10923 + 5000), ONE_FX, HALF_FX);
		end
		// Sector edges and the top of the last sector.
		send_pixel(17'd10923, ONE_FX, 17'd20000);
		send_pixel(17'd10922, 17'd50000, 17'd45000);
		send_pixel(17'd65535, ONE_FX, HALF_FX);
		send_pixel(17'd1, 17'd1, 17'd1);

		// Random part; the tail runs without idling on either side.
		for (int n = 0; n < RANDOM_COUNT; n++) begin
			if (n == CALM_FROM) begin
				calm = 1'b1;
			end
			send_pixel(draw_fraction(), draw_fraction(), draw_fraction());
		end
		s_axis_tvalid <= 1'b0;

		// Let every expected result arrive, then watch for stray beats a while longer.
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/hsl2rgb_pkg.sv
sv/hsl2rgb_chroma.sv
sv/hsl2rgb_sector.sv
sv/hsl2rgb_quant.sv
sv/hsl_to_rgb_pixel_core.sv
sv/hsl2rgb_checker.sv
bench/hsl_to_rgb_pixel_checker.sv
bench/tb_hsl_to_rgb_pixel_core.sv
